[hw/rtl/nma_pkg.sv]
// Shared types and constants for the nearest-medoid L1 assignment block.
package nma_pkg;

	localparam int VAL_W   = 16;
	localparam int ACC_W   = 22;
	localparam int CNT_W   = 7;
	localparam int MIDX_W  = 4;
	localparam int EIDX_W  = 6;
	localparam int CNUM_W  = 5;
	localparam int CIDX_W  = 1;

	localparam logic [ACC_W-1:0] ACC_MAX = 22'h3FFFFF;

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_POINT = 1'b1;

	localparam logic [CIDX_W-1:0] REG_DIMS  = 1'b0;
	localparam logic [CIDX_W-1:0] REG_COUNT = 1'b1;

	localparam logic [CNT_W-1:0]  DIMS_RST  = 7'd32;
	localparam logic [CNUM_W-1:0] COUNT_RST = 5'd16;

	typedef struct packed {
		logic              action;
		logic [MIDX_W-1:0] medoid_index;
		logic [EIDX_W-1:0] element_index;
		logic [VAL_W-1:0]  value;
	} in_t;

	typedef struct packed {
		logic [MIDX_W-1:0] nearest_medoid;
		logic [ACC_W-1:0]  l1_distance;
	} out_t;

	// control fanned out from the front end to every cell
	typedef struct packed {
		logic load;
		logic rd;
		logic acc;
	} cell_ctl_t;

	// running minimum handed along the chain
	typedef struct packed {
		logic              vld;
		logic              has;
		logic [MIDX_W-1:0] idx;
		logic [ACC_W-1:0]  score;
	} tok_t;

endpackage

[hw/rtl/nearest_medoid_l1_assign.sv]
// Nearest-medoid assignment by L1 distance: front end, cell chain and result staging.
//
//  channel | direction | handshake            | payload
//  in      | in        | in_valid / in_stall  | in_data  (nma_pkg::in_t)
//  out     | out       | out_valid / out_stall| out_data (nma_pkg::out_t)
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Load items and all but the last element of a point do not stall the input.
// The last element of a point stalls the input until its result reaches out_data:
// the running minimum walks the cell chain one cell a cycle and clears each
// accumulator as it passes. A result waiting on out_stall does not block input
// until the following point ends. Reset clears counters, accumulators and
// handshake state; medoid stores are not cleared.
module nearest_medoid_l1_assign #(
	parameter int MAX_MEDOIDS = 16,
	parameter int MAX_DIMS    = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  nma_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output nma_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [nma_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [nma_pkg::CNT_W-1:0]     cfg_data
);

	localparam int AW = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;

	logic [nma_pkg::CNT_W-1:0]  dims_q;
	logic [nma_pkg::CNUM_W-1:0] count_q;
	logic [nma_pkg::CNT_W-1:0]  dims_eff;
	logic [nma_pkg::CNT_W-1:0]  elem_cnt_q;
	logic [nma_pkg::CNT_W-1:0]  cnt_next;
	logic                       in_xfer;
	logic                       is_pt;
	logic                       last;
	logic                       busy_q;
	logic                       acc_s1;
	logic                       last_s1;
	logic [nma_pkg::VAL_W-1:0]  val_s1;
	logic                       start_q;
	nma_pkg::cell_ctl_t         ctl;
	nma_pkg::tok_t              tok [MAX_MEDOIDS+1];
	logic [MAX_MEDOIDS-1:0]     tok_vld;
	logic                       pend_vld_q;
	nma_pkg::out_t              pend_q;
	logic                       out_vld_q;
	nma_pkg::out_t              out_q;
	logic                       move;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= nma_pkg::DIMS_RST;
			count_q <= nma_pkg::COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				nma_pkg::REG_DIMS:  dims_q  <= cfg_data;
				nma_pkg::REG_COUNT: count_q <= cfg_data[nma_pkg::CNUM_W-1:0];
				default: ;
			endcase
		end
	end

	assign dims_eff = (dims_q == '0) ? nma_pkg::CNT_W'(1)
		: ((int'(dims_q) > MAX_DIMS) ? nma_pkg::CNT_W'(MAX_DIMS) : dims_q);

	// front end
	assign in_stall = busy_q;
	assign in_xfer  = in_valid && !in_stall;
	assign is_pt    = in_data.action == nma_pkg::ACT_POINT;
	assign cnt_next = elem_cnt_q + nma_pkg::CNT_W'(1);
	assign last     = cnt_next >= dims_eff;

	assign ctl.load = in_xfer && (in_data.action == nma_pkg::ACT_LOAD)
		&& (int'(in_data.element_index) < MAX_DIMS);
	assign ctl.rd   = in_xfer && is_pt;
	assign ctl.acc  = acc_s1;

	assign move = pend_vld_q && (!out_vld_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= '0;
			busy_q     <= 1'b0;
			acc_s1     <= 1'b0;
			last_s1    <= 1'b0;
			start_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			acc_s1  <= ctl.rd && (int'(elem_cnt_q) < MAX_DIMS);
			last_s1 <= ctl.rd && last;
			start_q <= last_s1;
			if (ctl.rd) begin
				elem_cnt_q <= last ? '0 : cnt_next;
				if (last) begin
					busy_q <= 1'b1;
				end
			end
			if (tok[MAX_MEDOIDS].vld) begin
				pend_vld_q <= 1'b1;
			end else if (move) begin
				pend_vld_q <= 1'b0;
				busy_q     <= 1'b0;
			end
			if (move) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		val_s1 <= in_data.value;
		if (tok[MAX_MEDOIDS].vld) begin
			pend_q.nearest_medoid <= tok[MAX_MEDOIDS].idx;
			pend_q.l1_distance    <= tok[MAX_MEDOIDS].score;
		end
		if (move) begin
			out_q <= pend_q;
		end
	end

	// cell chain
	always_comb begin
		tok[0]     = '0;
		tok[0].vld = start_q;
	end

	for (genvar j = 0; j < MAX_MEDOIDS; j++) begin : g_cell
		nma_cell #(
			.MAX_DIMS (MAX_DIMS),
			.J        (j)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.medoid_index (in_data.medoid_index),
			.waddr        (in_data.element_index[AW-1:0]),
			.raddr        (elem_cnt_q[AW-1:0]),
			.wdata        (in_data.value),
			.val_s1       (val_s1),
			.count        (count_q),
			.tok_in       (tok[j]),
			.tok_out      (tok[j+1])
		);
		assign tok_vld[j] = tok[j+1].vld;
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// a single search is in flight at any time
	a_one_search: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one minimum in the cell chain");

	a_start_clear: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> (tok_vld == '0) && !pend_vld_q)
		else $error("search started while a previous one is still pending");

	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> busy_q)
		else $error("pending result without input held off");

	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.rd && last) |=> busy_q && last_s1)
		else $error("end of point did not hold off the input");

endmodule

[hw/rtl/nma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/nma_cell.sv]
// One medoid cell: element store, L1 accumulator and a stage of the minimum chain.
module nma_cell #(
	parameter int MAX_DIMS = 64,
	parameter int J        = 0
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  nma_pkg::cell_ctl_t                       ctl,
	input  logic [nma_pkg::MIDX_W-1:0]               medoid_index,
	input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] waddr,
	input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] raddr,
	input  logic [nma_pkg::VAL_W-1:0]                wdata,
	input  logic [nma_pkg::VAL_W-1:0]                val_s1,
	input  logic [nma_pkg::CNUM_W-1:0]               count,
	input  nma_pkg::tok_t                            tok_in,
	output nma_pkg::tok_t                            tok_out
);

	logic                         en;
	logic                         we;
	logic [nma_pkg::VAL_W-1:0]    mval;
	logic signed [nma_pkg::VAL_W:0] diff;
	logic [nma_pkg::VAL_W:0]      mag;
	logic [nma_pkg::ACC_W:0]      sum;
	logic [nma_pkg::ACC_W-1:0]    acc_q;
	logic                         take;
	logic                         tvld_q;
	logic                         has_q;
	logic [nma_pkg::MIDX_W-1:0]   idx_q;
	logic [nma_pkg::ACC_W-1:0]    score_q;

	// medoid 0 always takes part, whatever the count register holds
	assign en = (J == 0) || (J < int'(count));
	assign we = ctl.load && (int'(medoid_index) == J);

	nma_ram #(
		.WIDTH (nma_pkg::VAL_W),
		.DEPTH (MAX_DIMS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (ctl.rd),
		.raddr (raddr),
		.rdata (mval)
	);

	assign diff = $signed({val_s1[nma_pkg::VAL_W-1], val_s1})
		- $signed({mval[nma_pkg::VAL_W-1], mval});
	assign mag  = diff[nma_pkg::VAL_W] ? (nma_pkg::VAL_W + 1)'(0) - diff : diff;
	assign sum  = {1'b0, acc_q} + (nma_pkg::ACC_W + 1)'(mag);

	assign take = en && (!tok_in.has || (acc_q < tok_in.score));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			tvld_q <= 1'b0;
		end else begin
			tvld_q <= tok_in.vld;
			// accumulator is read and cleared as the minimum passes
			if (tok_in.vld) begin
				acc_q <= '0;
			end else if (ctl.acc && en) begin
				acc_q <= sum[nma_pkg::ACC_W] ? nma_pkg::ACC_MAX : sum[nma_pkg::ACC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.vld) begin
			if (take) begin
				has_q   <= 1'b1;
				idx_q   <= nma_pkg::MIDX_W'(J);
				score_q <= acc_q;
			end else begin
				has_q   <= tok_in.has;
				idx_q   <= tok_in.idx;
				score_q <= tok_in.score;
			end
		end
	end

	always_comb begin
		tok_out.vld   = tvld_q;
		tok_out.has   = has_q;
		tok_out.idx   = idx_q;
		tok_out.score = score_q;
	end

endmodule
